@@ design/gpr_pkg.sv @@
`default_nettype none
package gpr_pkg;

    localparam int PHASE_BITS = 16;
    localparam int FRAC_BITS  = 12;
    localparam int TRIG_FB    = PHASE_BITS - 7;

    // register map, word index
    localparam logic [2:0] REG_DC_BUS_REF   = 3'd0;
    localparam logic [2:0] REG_CURRENT_LIM  = 3'd1;
    localparam logic [2:0] REG_BUS_KP       = 3'd2;
    localparam logic [2:0] REG_BUS_KI       = 3'd3;
    localparam logic [2:0] REG_RES_KP       = 3'd4;
    localparam logic [2:0] REG_RES_KI       = 3'd5;
    localparam logic [2:0] REG_PLL_KP       = 3'd6;
    localparam logic [2:0] REG_PLL_KI       = 3'd7;

    // fixed-point loop constants
    localparam logic signed [32:0] LP_DECAY  = 33'sd18889266;
    localparam logic signed [32:0] LP_GAIN   = 33'sd42391;
    localparam logic signed [32:0] STEP_Q28  = 33'sd26844;
    localparam logic        [33:0] W0_Q24    = 34'd6324861424;
    localparam logic signed [32:0] TURN_Q40  = 33'sd17499271;
    localparam logic signed [32:0] RES_COS   = 33'sd1072978901;
    localparam logic signed [32:0] RES_SIN   = 33'sd40469525;
    localparam logic signed [32:0] RES_IN_B  = 33'sd2072285;
    localparam longint LOAD_AMP_Q20 = 163120143;
    localparam longint LOAD_AMP_INT =
        (LOAD_AMP_Q20 + (64'sd1 <<< (20 - FRAC_BITS - 1))) >>> (20 - FRAC_BITS);
    localparam logic signed [32:0] LOAD_AMP  = 33'(LOAD_AMP_INT);
    localparam logic signed [71:0] BASE_CURRENT = 72'sd3 <<< FRAC_BITS;

    typedef struct packed {
        logic [22:0] dc_bus_reference;
        logic [22:0] current_limit;
        logic [23:0] bus_kp;
        logic [23:0] bus_ki;
        logic [23:0] res_kp;
        logic [23:0] res_ki;
        logic [23:0] pll_kp;
        logic [23:0] pll_ki;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_COS, ST_PD, ST_DEC, ST_GAIN, ST_KIE, ST_XSH, ST_XSL, ST_KPE, ST_WH, ST_WL,
        ST_SIN, ST_BKI, ST_YSH, ST_YSL, ST_BKP, ST_AMP, ST_KIU, ST_CXA, ST_SZB,
        ST_USH, ST_USL, ST_CZB, ST_SXA, ST_UBH, ST_UBL, ST_RKP, ST_LOAD
    } step_t;

    typedef enum logic [1:0] {
        FS_IDLE, FS_MUL, FS_WB, FS_FINISH
    } fsm_t;

    typedef struct packed {
        logic  capture;
        logic  mul;
        logic  wb;
        logic  load_out;
        step_t step;
    } dp_cmd_t;

    function automatic logic signed [71:0] rnd72(input logic signed [71:0] x,
                                                 input int unsigned s);
        logic signed [71:0] half;
        half = 72'sd1 <<< (s - 1);
        return (x + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) return 32'sh7fffffff;
        if (x < -72'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [71:0] x);
        if (x > 72'sd8388607) return 24'sh7fffff;
        if (x < -72'sd8388608) return 24'sh800000;
        return x[23:0];
    endfunction

    // quarter-wave sine, Q15
    function automatic logic [15:0] sine_tab(input logic [5:0] k);
        case (k)
            6'd0:  return 16'd0;
            6'd1:  return 16'd1608;
            6'd2:  return 16'd3212;
            6'd3:  return 16'd4808;
            6'd4:  return 16'd6393;
            6'd5:  return 16'd7962;
            6'd6:  return 16'd9512;
            6'd7:  return 16'd11039;
            6'd8:  return 16'd12540;
            6'd9:  return 16'd14010;
            6'd10: return 16'd15447;
            6'd11: return 16'd16846;
            6'd12: return 16'd18205;
            6'd13: return 16'd19520;
            6'd14: return 16'd20788;
            6'd15: return 16'd22006;
            6'd16: return 16'd23170;
            6'd17: return 16'd24279;
            6'd18: return 16'd25330;
            6'd19: return 16'd26320;
            6'd20: return 16'd27246;
            6'd21: return 16'd28106;
            6'd22: return 16'd28899;
            6'd23: return 16'd29622;
            6'd24: return 16'd30274;
            6'd25: return 16'd30853;
            6'd26: return 16'd31357;
            6'd27: return 16'd31786;
            6'd28: return 16'd32138;
            6'd29: return 16'd32413;
            6'd30: return 16'd32610;
            6'd31: return 16'd32729;
            6'd32: return 16'd32768;
            default: return 16'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ design/grid_pll_resonant_current_pwm.sv @@
// Each request runs a chain of multiply steps, each a multiply state then a write-back state,
// and then an output load; the chain starts at ST_COS when the PLL advances, else at ST_SIN.
// A new request is taken only once the last is through, as the one 33x33 multiplier is shared.
// The output register holds a result until taken while the next request is accepted.
// Reset (aresetn low, synchronous) clears phase and loop states, restores default
// register values and drops m_valid.
`default_nettype none
module grid_pll_resonant_current_pwm (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_pll_update,
    input  wire logic signed [23:0] s_triangle_carrier,
    input  wire logic signed [23:0] s_grid_voltage,
    input  wire logic signed [23:0] s_grid_current,
    input  wire logic signed [23:0] s_bus_voltage,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_shunt_gate,
    output logic                    m_series_gate,
    output logic signed [23:0]      m_shunt_voltage_ref,
    output logic signed [23:0]      m_current_ref
);

    gpr_pkg::cfg_t    cfg;
    gpr_pkg::dp_cmd_t cmd;

    assign pready = 1'b1;

    gpr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    gpr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_pll_update (s_pll_update),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd)
    );

    gpr_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .cfg                 (cfg),
        .s_triangle_carrier  (s_triangle_carrier),
        .s_grid_voltage      (s_grid_voltage),
        .s_grid_current      (s_grid_current),
        .s_bus_voltage       (s_bus_voltage),
        .m_shunt_gate        (m_shunt_gate),
        .m_series_gate       (m_series_gate),
        .m_shunt_voltage_ref (m_shunt_voltage_ref),
        .m_current_ref       (m_current_ref)
    );

endmodule
`default_nettype wire

@@ design/gpr_cfg.sv @@
`default_nettype none
module gpr_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output gpr_pkg::cfg_t      cfg
);

    gpr_pkg::cfg_t cfg_reg, cfg_next;
    logic          wr_en;

    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[4:2])
                gpr_pkg::REG_DC_BUS_REF:  cfg_next.dc_bus_reference = pwdata[22:0];
                gpr_pkg::REG_CURRENT_LIM: cfg_next.current_limit    = pwdata[22:0];
                gpr_pkg::REG_BUS_KP:      cfg_next.bus_kp           = pwdata[23:0];
                gpr_pkg::REG_BUS_KI:      cfg_next.bus_ki           = pwdata[23:0];
                gpr_pkg::REG_RES_KP:      cfg_next.res_kp           = pwdata[23:0];
                gpr_pkg::REG_RES_KI:      cfg_next.res_ki           = pwdata[23:0];
                gpr_pkg::REG_PLL_KP:      cfg_next.pll_kp           = pwdata[23:0];
                gpr_pkg::REG_PLL_KI:      cfg_next.pll_ki           = pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gpr_pkg::REG_DC_BUS_REF:  prdata = {9'b0, cfg_reg.dc_bus_reference};
            gpr_pkg::REG_CURRENT_LIM: prdata = {9'b0, cfg_reg.current_limit};
            gpr_pkg::REG_BUS_KP:      prdata = {8'b0, cfg_reg.bus_kp};
            gpr_pkg::REG_BUS_KI:      prdata = {8'b0, cfg_reg.bus_ki};
            gpr_pkg::REG_RES_KP:      prdata = {8'b0, cfg_reg.res_kp};
            gpr_pkg::REG_RES_KI:      prdata = {8'b0, cfg_reg.res_ki};
            gpr_pkg::REG_PLL_KP:      prdata = {8'b0, cfg_reg.pll_kp};
            gpr_pkg::REG_PLL_KI:      prdata = {8'b0, cfg_reg.pll_ki};
            default:                  prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dc_bus_reference <= 23'd1904640;
            cfg_reg.current_limit    <= 23'd122880;
            cfg_reg.bus_kp           <= 24'd2048;
            cfg_reg.bus_ki           <= 24'd81920;
            cfg_reg.res_kp           <= 24'd40960;
            cfg_reg.res_ki           <= 24'd4096000;
            cfg_reg.pll_kp           <= 24'd614;
            cfg_reg.pll_ki           <= 24'd4710;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ design/gpr_ctrl.sv @@
`default_nettype none
module gpr_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_pll_update,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gpr_pkg::dp_cmd_t   cmd
);

    gpr_pkg::fsm_t  state_reg, state_next;
    gpr_pkg::step_t step_reg, step_next;
    logic           m_valid_reg, m_valid_next;
    logic           out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            gpr_pkg::FS_IDLE: begin
                if (s_valid) begin
                    state_next = gpr_pkg::FS_MUL;
                    step_next  = s_pll_update ? gpr_pkg::ST_COS : gpr_pkg::ST_SIN;
                end
            end
            gpr_pkg::FS_MUL: state_next = gpr_pkg::FS_WB;
            gpr_pkg::FS_WB: begin
                if (step_reg == gpr_pkg::ST_LOAD) begin
                    state_next = gpr_pkg::FS_FINISH;
                end else begin
                    state_next = gpr_pkg::FS_MUL;
                    step_next  = gpr_pkg::step_t'(step_reg + 5'd1);
                end
            end
            gpr_pkg::FS_FINISH: begin
                if (out_free) state_next = gpr_pkg::FS_IDLE;
            end
            default: state_next = gpr_pkg::FS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = (state_reg == gpr_pkg::FS_IDLE);
        cmd.capture  = (state_reg == gpr_pkg::FS_IDLE) && s_valid;
        cmd.mul      = (state_reg == gpr_pkg::FS_MUL);
        cmd.wb       = (state_reg == gpr_pkg::FS_WB);
        cmd.load_out = (state_reg == gpr_pkg::FS_FINISH) && out_free;
        cmd.step     = step_reg;
        m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gpr_pkg::FS_IDLE;
            step_reg    <= gpr_pkg::ST_COS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ design/gpr_dp.sv @@
`default_nettype none
module gpr_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire gpr_pkg::dp_cmd_t    cmd,
    input  wire gpr_pkg::cfg_t       cfg,
    input  wire logic signed [23:0]  s_triangle_carrier,
    input  wire logic signed [23:0]  s_grid_voltage,
    input  wire logic signed [23:0]  s_grid_current,
    input  wire logic signed [23:0]  s_bus_voltage,
    output logic                     m_shunt_gate,
    output logic                     m_series_gate,
    output logic signed [23:0]       m_shunt_voltage_ref,
    output logic signed [23:0]       m_current_ref
);

    localparam int PB = gpr_pkg::PHASE_BITS;
    localparam int FB = gpr_pkg::TRIG_FB;

    // sample latches
    logic signed [23:0] tri_reg, eg_reg, ig_reg, vbus_reg;

    // loop state
    logic [PB-1:0]      phase_reg, phase_next;
    logic signed [31:0] lp1_reg, lp1_next, lp2_reg, lp2_next;
    logic signed [31:0] pll_int_reg, pll_int_next, bus_int_reg, bus_int_next;
    logic signed [31:0] res_a_reg, res_a_next, res_b_reg, res_b_next;
    logic signed [31:0] prev_err_reg, prev_err_next;

    // working registers
    logic signed [65:0] prod_reg;
    logic signed [71:0] acc_reg, acc_next;
    logic signed [16:0] cs_reg, cs_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [33:0] t1_reg, t1_next;
    logic signed [48:0] x_reg, x_next;
    logic        [33:0] w_reg, w_next;
    logic signed [49:0] y_reg, y_next;
    logic signed [23:0] amp_reg, amp_next;
    logic signed [24:0] igref_reg, igref_next;
    logic signed [25:0] enow_reg, enow_next;
    logic signed [38:0] u2_reg, u2_next;
    logic signed [35:0] ta_reg, ta_next, tb_reg, tb_next;
    logic signed [23:0] vsh_reg, vsh_next;
    logic signed [24:0] vse_reg, vse_next;

    logic               sg_reg, seg_reg;
    logic signed [23:0] out_vsh_reg, out_ig_reg;

    // multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [24:0] err;
    logic signed [71:0] p72, full72;

    // sine/cosine interpolation
    logic [PB-1:0] trig_p;
    logic [1:0]    quad;
    logic [PB-2:0] uq;
    logic [5:0]    ti, tj;
    logic [FB-1:0] tf;
    logic [15:0]   tab_i, tab_j;
    logic signed [16:0] dtab;
    logic signed [71:0] trig_r;
    logic signed [16:0] trig_val;

    assign trig_p = (cmd.step == gpr_pkg::ST_COS)
                  ? phase_reg + {2'b01, {(PB-2){1'b0}}} : phase_reg;
    assign quad   = trig_p[PB-1:PB-2];
    assign uq     = quad[0] ? ({1'b1, {(PB-2){1'b0}}} - {1'b0, trig_p[PB-3:0]})
                            : {1'b0, trig_p[PB-3:0]};
    assign ti     = uq[PB-2:FB];
    assign tf     = uq[FB-1:0];
    assign tj     = (ti < 6'd32) ? ti + 6'd1 : 6'd32;
    assign tab_i  = gpr_pkg::sine_tab(ti);
    assign tab_j  = gpr_pkg::sine_tab(tj);
    assign dtab   = signed'({1'b0, tab_j}) - signed'({1'b0, tab_i});
    assign trig_r = gpr_pkg::rnd72((signed'(72'(tab_i)) <<< FB) + p72, FB);
    assign trig_val = quad[1] ? -trig_r[16:0] : trig_r[16:0];

    assign err    = signed'({2'b0, cfg.dc_bus_reference}) - 25'(vbus_reg);
    assign p72    = 72'(prod_reg);
    assign full72 = acc_reg + p72;

    always_comb begin
        case (cmd.step)
            gpr_pkg::ST_COS, gpr_pkg::ST_SIN: begin
                mul_a = 33'(dtab);
                mul_b = signed'(33'(tf));
            end
            gpr_pkg::ST_PD:   begin mul_a = 33'(eg_reg);   mul_b = 33'(cs_reg); end
            gpr_pkg::ST_DEC:  begin mul_a = 33'(lp1_reg);  mul_b = gpr_pkg::LP_DECAY; end
            gpr_pkg::ST_GAIN: begin mul_a = diff_reg;      mul_b = gpr_pkg::LP_GAIN; end
            gpr_pkg::ST_KIE:  begin mul_a = 33'(lp2_reg);  mul_b = {9'b0, cfg.pll_ki}; end
            gpr_pkg::ST_XSH: begin
                mul_a = 33'(signed'(x_reg[48:24]));
                mul_b = gpr_pkg::STEP_Q28;
            end
            gpr_pkg::ST_XSL:  begin mul_a = {9'b0, x_reg[23:0]}; mul_b = gpr_pkg::STEP_Q28; end
            gpr_pkg::ST_KPE:  begin mul_a = 33'(lp2_reg);  mul_b = {9'b0, cfg.pll_kp}; end
            gpr_pkg::ST_WH:   begin mul_a = {23'b0, w_reg[33:24]}; mul_b = gpr_pkg::TURN_Q40; end
            gpr_pkg::ST_WL:   begin mul_a = {9'b0, w_reg[23:0]}; mul_b = gpr_pkg::TURN_Q40; end
            gpr_pkg::ST_BKI:  begin mul_a = 33'(err);      mul_b = {9'b0, cfg.bus_ki}; end
            gpr_pkg::ST_YSH: begin
                mul_a = 33'(signed'(y_reg[49:24]));
                mul_b = gpr_pkg::STEP_Q28;
            end
            gpr_pkg::ST_YSL:  begin mul_a = {9'b0, y_reg[23:0]}; mul_b = gpr_pkg::STEP_Q28; end
            gpr_pkg::ST_BKP:  begin mul_a = 33'(err);      mul_b = {9'b0, cfg.bus_kp}; end
            gpr_pkg::ST_AMP:  begin mul_a = 33'(amp_reg);  mul_b = 33'(cs_reg); end
            gpr_pkg::ST_KIU:  begin mul_a = 33'(prev_err_reg); mul_b = {9'b0, cfg.res_ki}; end
            gpr_pkg::ST_CXA:  begin mul_a = 33'(res_a_reg); mul_b = gpr_pkg::RES_COS; end
            gpr_pkg::ST_SZB:  begin mul_a = 33'(res_b_reg); mul_b = gpr_pkg::RES_SIN; end
            gpr_pkg::ST_USH: begin
                mul_a = 33'(signed'(u2_reg[38:24]));
                mul_b = gpr_pkg::RES_SIN;
            end
            gpr_pkg::ST_USL:  begin mul_a = {9'b0, u2_reg[23:0]}; mul_b = gpr_pkg::RES_SIN; end
            gpr_pkg::ST_CZB:  begin mul_a = 33'(res_b_reg); mul_b = gpr_pkg::RES_COS; end
            gpr_pkg::ST_SXA:  begin mul_a = 33'(res_a_reg); mul_b = gpr_pkg::RES_SIN; end
            gpr_pkg::ST_UBH: begin
                mul_a = 33'(signed'(u2_reg[38:24]));
                mul_b = gpr_pkg::RES_IN_B;
            end
            gpr_pkg::ST_UBL:  begin mul_a = {9'b0, u2_reg[23:0]}; mul_b = gpr_pkg::RES_IN_B; end
            gpr_pkg::ST_RKP:  begin mul_a = 33'(enow_reg); mul_b = {9'b0, cfg.res_kp}; end
            gpr_pkg::ST_LOAD: begin mul_a = gpr_pkg::LOAD_AMP; mul_b = 33'(cs_reg); end
            default:          begin mul_a = 33'sd0; mul_b = 33'sd0; end
        endcase
    end

    always_comb begin
        logic signed [71:0] tmp;
        logic signed [71:0] lim;
        phase_next    = phase_reg;
        lp1_next      = lp1_reg;
        lp2_next      = lp2_reg;
        pll_int_next  = pll_int_reg;
        bus_int_next  = bus_int_reg;
        res_a_next    = res_a_reg;
        res_b_next    = res_b_reg;
        prev_err_next = prev_err_reg;
        acc_next      = acc_reg;
        cs_next       = cs_reg;
        diff_next     = diff_reg;
        t1_next       = t1_reg;
        x_next        = x_reg;
        w_next        = w_reg;
        y_next        = y_reg;
        amp_next      = amp_reg;
        igref_next    = igref_reg;
        enow_next     = enow_reg;
        u2_next       = u2_reg;
        ta_next       = ta_reg;
        tb_next       = tb_reg;
        vsh_next      = vsh_reg;
        vse_next      = vse_reg;
        tmp           = 72'sd0;
        lim           = 72'sd0;
        if (cmd.wb) begin
            case (cmd.step)
                gpr_pkg::ST_COS, gpr_pkg::ST_SIN: cs_next = trig_val;
                gpr_pkg::ST_PD: begin
                    tmp       = gpr_pkg::rnd72(p72, 15);
                    diff_next = 33'(tmp - 72'(lp2_reg));
                    lp2_next  = gpr_pkg::sat32(72'(lp2_reg)
                                + gpr_pkg::rnd72(72'(lp1_reg), 16));
                end
                gpr_pkg::ST_DEC:
                    t1_next = 34'(72'(lp1_reg) - gpr_pkg::rnd72(p72, 32));
                gpr_pkg::ST_GAIN:
                    lp1_next = gpr_pkg::sat32(72'(t1_reg) + gpr_pkg::rnd72(p72, 16));
                gpr_pkg::ST_KIE:
                    x_next = 49'(gpr_pkg::rnd72(p72, 8));
                gpr_pkg::ST_XSH, gpr_pkg::ST_WH, gpr_pkg::ST_YSH, gpr_pkg::ST_USH,
                gpr_pkg::ST_UBH:
                    acc_next = p72 <<< 24;
                gpr_pkg::ST_XSL:
                    pll_int_next = gpr_pkg::sat32(72'(pll_int_reg)
                        + gpr_pkg::rnd72(full72, gpr_pkg::FRAC_BITS + 8));
                gpr_pkg::ST_KPE: begin
                    tmp    = 72'(gpr_pkg::sat32(72'(pll_int_reg)
                             + gpr_pkg::rnd72(p72 <<< 4, gpr_pkg::FRAC_BITS - 8)));
                    w_next = 34'(signed'(72'(gpr_pkg::W0_Q24)) + tmp);
                end
                gpr_pkg::ST_WL: begin
                    tmp        = gpr_pkg::rnd72(full72, 64 - PB);
                    phase_next = phase_reg + tmp[PB-1:0];
                end
                gpr_pkg::ST_BKI:
                    y_next = 50'(p72);
                gpr_pkg::ST_YSL:
                    bus_int_next = gpr_pkg::sat32(72'(bus_int_reg)
                                   + gpr_pkg::rnd72(full72, 36));
                gpr_pkg::ST_BKP: begin
                    tmp = gpr_pkg::rnd72(p72, 12) + gpr_pkg::rnd72(72'(bus_int_reg), 4)
                          + gpr_pkg::BASE_CURRENT;
                    lim = signed'(72'(cfg.current_limit));
                    if (tmp > lim) tmp = lim;
                    if (tmp < -lim) tmp = -lim;
                    amp_next = tmp[23:0];
                end
                gpr_pkg::ST_AMP: begin
                    tmp        = gpr_pkg::rnd72(p72, 15);
                    igref_next = 25'(tmp);
                    enow_next  = 26'(tmp - 72'(ig_reg));
                end
                gpr_pkg::ST_KIU: begin
                    tmp           = gpr_pkg::rnd72(p72, 12);
                    u2_next       = 39'(tmp <<< 1);
                    prev_err_next = 32'(enow_reg);
                end
                gpr_pkg::ST_CXA:
                    ta_next = 36'(gpr_pkg::rnd72(p72, 30));
                gpr_pkg::ST_SZB:
                    ta_next = 36'(72'(ta_reg) + gpr_pkg::rnd72(p72, 30));
                gpr_pkg::ST_USL:
                    ta_next = 36'(72'(ta_reg) + gpr_pkg::rnd72(full72, 30));
                gpr_pkg::ST_CZB:
                    tb_next = 36'(gpr_pkg::rnd72(p72, 30));
                gpr_pkg::ST_SXA:
                    tb_next = 36'(72'(tb_reg) - gpr_pkg::rnd72(p72, 30));
                gpr_pkg::ST_UBL: begin
                    res_b_next = gpr_pkg::sat32(72'(tb_reg) - gpr_pkg::rnd72(full72, 40));
                    tmp = 72'(ta_reg);
                    lim = signed'(72'(cfg.dc_bus_reference));
                    if (tmp > lim) tmp = lim;
                    if (tmp < -lim) tmp = -lim;
                    res_a_next = tmp[31:0];
                end
                gpr_pkg::ST_RKP:
                    vsh_next = gpr_pkg::sat24(72'(res_a_reg) + gpr_pkg::rnd72(p72, 12)
                                              + 72'(eg_reg));
                gpr_pkg::ST_LOAD:
                    vse_next = 25'(72'(eg_reg) - gpr_pkg::rnd72(p72, 15));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            lp1_reg      <= '0;
            lp2_reg      <= '0;
            pll_int_reg  <= '0;
            bus_int_reg  <= '0;
            res_a_reg    <= '0;
            res_b_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            lp1_reg      <= lp1_next;
            lp2_reg      <= lp2_next;
            pll_int_reg  <= pll_int_next;
            bus_int_reg  <= bus_int_next;
            res_a_reg    <= res_a_next;
            res_b_reg    <= res_b_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tri_reg  <= s_triangle_carrier;
            eg_reg   <= s_grid_voltage;
            ig_reg   <= s_grid_current;
            vbus_reg <= s_bus_voltage;
        end
        if (cmd.mul) prod_reg <= mul_a * mul_b;
        acc_reg   <= acc_next;
        cs_reg    <= cs_next;
        diff_reg  <= diff_next;
        t1_reg    <= t1_next;
        x_reg     <= x_next;
        w_reg     <= w_next;
        y_reg     <= y_next;
        amp_reg   <= amp_next;
        igref_reg <= igref_next;
        enow_reg  <= enow_next;
        u2_reg    <= u2_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        vsh_reg   <= vsh_next;
        vse_reg   <= vse_next;
        if (cmd.load_out) begin
            sg_reg      <= (vsh_reg >= tri_reg);
            seg_reg     <= (vse_reg >= 25'(tri_reg));
            out_vsh_reg <= vsh_reg;
            out_ig_reg  <= igref_reg[23:0];
        end
    end

    assign m_shunt_gate        = sg_reg;
    assign m_series_gate       = seg_reg;
    assign m_shunt_voltage_ref = out_vsh_reg;
    assign m_current_ref       = out_ig_reg;

endmodule
`default_nettype wire

@@ design/gpr_checker.sv @@
`default_nettype none
module gpr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [23:0] m_shunt_voltage_ref,
    input wire logic [23:0] m_current_ref
);

    // out of reset: idle and nothing pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("not idle after reset");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // a result never appears right after a request is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result too early");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("m_valid dropped");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_shunt_voltage_ref) && $stable(m_current_ref)))
        else $error("stalled result changed");

endmodule

bind grid_pll_resonant_current_pwm gpr_checker u_gpr_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_shunt_voltage_ref (m_shunt_voltage_ref),
    .m_current_ref       (m_current_ref)
);
`default_nettype wire
